@@ sv/bil_pkg.sv @@
`default_nettype none
package bil_pkg;

	localparam int OP_W      = 3;
	localparam int VAL_W     = 32;
	localparam int POS_W     = 8;
	localparam int CNT_W     = 9;
	localparam int DEPTH_DEF = 256;

	localparam logic [OP_W-1:0] OP_CLEAR        = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND       = 3'd1;
	localparam logic [OP_W-1:0] OP_FIND_FIRST   = 3'd2;
	localparam logic [OP_W-1:0] OP_FIND_LAST    = 3'd3;
	localparam logic [OP_W-1:0] OP_REMOVE_SWAP  = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE_SHIFT = 3'd5;

endpackage
`default_nettype wire

@@ sv/bil_ram.sv @@
`default_nettype none
module bil_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ sv/bil_seq.sv @@
`default_nettype none
module bil_seq import bil_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [OP_W-1:0]                        operation,
	input  wire logic [VAL_W-1:0]                       value,
	input  wire logic [POS_W-1:0]                       position,
	output logic                                        done,
	output logic                                        ok,
	output logic      [POS_W-1:0]                       found_position,
	output logic      [CNT_W-1:0]                       count,
	output logic                                        ram_we,
	output logic      [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_waddr,
	output logic      [VAL_W-1:0]                       ram_wdata,
	output logic      [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_raddr,
	input  wire logic [VAL_W-1:0]                       ram_rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);
	localparam int CW = (LW > POS_W) ? LW : POS_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FIND = 2'd1;
	localparam logic [1:0] ST_MOVE = 2'd2;

	logic [1:0]       state_q;
	logic [LW-1:0]    len_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    end_q;
	logic             up_q;
	logic             issue_q;
	logic             swap_q;
	logic [VAL_W-1:0] val_q;
	logic [AW-1:0]    pos_q;
	logic             vld_s1;
	logic             last_s1;
	logic [AW-1:0]    idx_s1;
	logic             done_q;
	logic             ok_q;
	logic [POS_W-1:0] fpos_q;

	logic             accept;
	logic             pos_ok;
	logic             full;
	logic [LW-1:0]    len_m1;
	logic [AW-1:0]    last_idx;
	logic             issue;
	logic             hit;
	logic             at_end;
	logic             acc_ok;

	assign accept   = start && (state_q == ST_IDLE);
	assign pos_ok   = CW'(position) < CW'(len_q);
	assign full     = len_q == LW'(DEPTH);
	assign len_m1   = len_q - LW'(1);
	assign last_idx = AW'(len_m1);
	assign issue    = (state_q != ST_IDLE) && issue_q;
	assign hit      = vld_s1 && (ram_rdata == val_q);
	assign at_end   = idx_q == end_q;

	assign busy           = state_q != ST_IDLE;
	assign done           = done_q;
	assign ok             = ok_q;
	assign found_position = fpos_q;
	assign count          = CNT_W'(len_q);
	assign ram_raddr      = idx_q;

	always_comb begin
		case (operation)
			OP_CLEAR:        acc_ok = 1'b1;
			OP_APPEND:       acc_ok = !full;
			OP_REMOVE_SWAP:  acc_ok = pos_ok;
			OP_REMOVE_SHIFT: acc_ok = pos_ok;
			default:         acc_ok = 1'b0;
		endcase
	end

	// append writes at accept, moves write back the word read in the cycle before
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(len_q);
		ram_wdata = value;
		if (accept && (operation == OP_APPEND) && !full) begin
			ram_we = 1'b1;
		end else if ((state_q == ST_MOVE) && vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = swap_q ? pos_q : AW'(idx_s1 - AW'(1));
			ram_wdata = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							OP_CLEAR: begin
								len_q  <= '0;
								done_q <= 1'b1;
							end
							OP_APPEND: begin
								if (!full) begin
									len_q <= len_q + LW'(1);
								end
								done_q <= 1'b1;
							end
							OP_FIND_FIRST, OP_FIND_LAST: begin
								if (len_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_FIND;
									issue_q <= 1'b1;
								end
							end
							OP_REMOVE_SWAP: begin
								if (pos_ok) begin
									len_q   <= len_m1;
									state_q <= ST_MOVE;
									issue_q <= 1'b1;
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_REMOVE_SHIFT: begin
								if (pos_ok) begin
									len_q <= len_m1;
									if (CW'(position) == CW'(len_m1)) begin
										done_q <= 1'b1;
									end else begin
										state_q <= ST_MOVE;
										issue_q <= 1'b1;
									end
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_FIND: begin
					if (issue) begin
						issue_q <= !at_end;
					end
					if (hit || (vld_s1 && last_s1)) begin
						state_q <= ST_IDLE;
						issue_q <= 1'b0;
						done_q  <= 1'b1;
					end
				end
				ST_MOVE: begin
					if (issue) begin
						issue_q <= !at_end;
					end
					if (vld_s1 && last_s1) begin
						state_q <= ST_IDLE;
						issue_q <= 1'b0;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					issue_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		last_s1 <= at_end;
		if (accept) begin
			val_q  <= value;
			pos_q  <= AW'(position);
			swap_q <= operation == OP_REMOVE_SWAP;
			ok_q   <= acc_ok;
			fpos_q <= '0;
			case (operation)
				OP_FIND_FIRST: begin
					idx_q <= '0;
					end_q <= last_idx;
					up_q  <= 1'b1;
				end
				OP_FIND_LAST: begin
					idx_q <= last_idx;
					end_q <= '0;
					up_q  <= 1'b0;
				end
				OP_REMOVE_SWAP: begin
					idx_q <= last_idx;
					end_q <= last_idx;
					up_q  <= 1'b1;
				end
				OP_REMOVE_SHIFT: begin
					idx_q <= AW'(position) + AW'(1);
					end_q <= last_idx;
					up_q  <= 1'b1;
				end
				default: begin
					idx_q <= '0;
					end_q <= '0;
					up_q  <= 1'b1;
				end
			endcase
		end else begin
			if (issue) begin
				idx_q <= up_q ? idx_q + AW'(1) : idx_q - AW'(1);
			end
			if ((state_q == ST_FIND) && (hit || (vld_s1 && last_s1))) begin
				ok_q   <= hit;
				fpos_q <= hit ? POS_W'(idx_s1) : '0;
			end else if ((state_q == ST_MOVE) && vld_s1 && last_s1) begin
				ok_q   <= 1'b1;
				fpos_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/bounded_integer_list_engine.sv @@
// channel   signals                               transfer when
// command   operation, value, position            start && !busy
// result    ok, found_position, count             done (one cycle, no stall)
//
// clear, append, unused codes, failed removes and finds on an empty list: result in the cycle after the command
// find: one entry read per cycle through the single ram read port
// remove swap: the last entry is moved into the removed position; remove shift: one entry moved per cycle
// remove shift of the last entry moves nothing: result in the cycle after the command
// arst_n clears the length and control state only; entries are undefined until written, no clearing pass
// done is a single-cycle strobe and the receiver cannot stall it
`default_nettype none
module bounded_integer_list_engine import bil_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [OP_W-1:0]   operation,
	input  wire logic [VAL_W-1:0]  value,
	input  wire logic [POS_W-1:0]  position,
	output logic                   done,
	output logic                   ok,
	output logic      [POS_W-1:0]  found_position,
	output logic      [CNT_W-1:0]  count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	bil_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.value          (value),
		.position       (position),
		.done           (done),
		.ok             (ok),
		.found_position (found_position),
		.count          (count),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata)
	);

	bil_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_CLEAR) |=> done && ok && (count == '0))
		else $error("clear result wrong");

	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_APPEND) |=> done)
		else $error("append result missing");

	a_fail_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> (found_position == '0)) else $error("failed result has position");
`endif

endmodule
`default_nettype wire
